// ===== hw/rtl/dllc_pkg.sv =====
// Shared types and codes for the linked-list cursor engine.
// No dependencies.
package dllc_pkg;

    typedef enum logic [4:0] {
        OP_CLEAR      = 5'd0,
        OP_INS_FIRST  = 5'd1,
        OP_INS_LAST   = 5'd2,
        OP_GO_FIRST   = 5'd3,
        OP_GO_LAST    = 5'd4,
        OP_GET_FIRST  = 5'd5,
        OP_GET_LAST   = 5'd6,
        OP_DEL_FIRST  = 5'd7,
        OP_DEL_LAST   = 5'd8,
        OP_DEL_AFTER  = 5'd9,
        OP_DEL_BEFORE = 5'd10,
        OP_INS_AFTER  = 5'd11,
        OP_INS_BEFORE = 5'd12,
        OP_GET_ACTIVE = 5'd13,
        OP_SET_ACTIVE = 5'd14,
        OP_NEXT       = 5'd15,
        OP_PREVIOUS   = 5'd16
    } t_op;

    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_FULL     = 2'd1;
    localparam logic [1:0] ERR_EMPTY    = 2'd2;
    localparam logic [1:0] ERR_INACTIVE = 2'd3;

    typedef struct packed {
        logic [4:0]         operation;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         error_code;
        logic               cursor_active;
        logic [6:0]         entry_count;
    } t_out_item;

    // Controller to datapath commands.
    typedef enum logic [2:0] {
        DC_IDLE,
        DC_START,   // latch item, issue first link read
        DC_READ2,   // issue second-level link read
        DC_EXEC     // commit writes and build result
    } t_dcmd;

    typedef struct packed {
        t_dcmd cmd;
    } t_ctl;

    typedef struct packed {
        logic done;
    } t_sts;

endpackage

// ===== hw/rtl/dllc_datapath.sv =====
// Datapath: node memories, head/tail/cursor registers, free map, result build.
// Depends on dllc_pkg.
module dllc_datapath #(
    parameter int POOL_DEPTH = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dllc_pkg::t_in_item  i_item,
    input  dllc_pkg::t_ctl      i_ctl,
    output dllc_pkg::t_sts      o_sts,
    output dllc_pkg::t_out_item o_result
);
    import dllc_pkg::*;

    localparam int AW = $clog2(POOL_DEPTH);
    localparam int IW = AW + 1;
    localparam int CW = $clog2(POOL_DEPTH + 1);
    localparam logic [IW-1:0] NONE = IW'(POOL_DEPTH);

    logic [VALUE_BITS-1:0] mem_val  [POOL_DEPTH];
    logic [IW-1:0]         mem_next [POOL_DEPTH];
    logic [IW-1:0]         mem_prev [POOL_DEPTH];

    logic [POOL_DEPTH-1:0] r_used;
    logic [IW-1:0]         r_head, r_tail, r_cur;
    logic [CW-1:0]         r_total;
    t_in_item              r_item;
    logic [IW-1:0]         r_a, r_b;       // link read results
    logic [IW-1:0]         r_free;         // lowest free slot, NONE if full
    logic [VALUE_BITS-1:0] r_rdval;        // registered value read
    t_out_item             r_res;

    // Lowest free slot, found while the first read is in flight.
    logic [IW-1:0] free_idx;
    always_comb begin
        free_idx = NONE;
        for (int i = POOL_DEPTH - 1; i >= 0; i--) begin
            if (!r_used[i]) free_idx = IW'(i);
        end
    end

    function automatic logic okx(input logic [IW-1:0] x);
        return x < NONE;
    endfunction

    t_op op;
    assign op = t_op'(r_item.operation);

    // First-level read address: which node's link to fetch.
    logic [IW-1:0] rd1_idx;
    logic          rd1_prev;
    always_comb begin
        rd1_idx  = i_item.operation == OP_DEL_FIRST ? r_head :
                   i_item.operation == OP_DEL_LAST  ? r_tail : r_cur;
        rd1_prev = i_item.operation == OP_DEL_LAST || i_item.operation == OP_DEL_BEFORE ||
                   i_item.operation == OP_INS_BEFORE || i_item.operation == OP_PREVIOUS;
    end

    logic [VALUE_BITS-1:0] val_in;
    assign val_in = VALUE_BITS'(r_item.value);

    logic signed [31:0] rd_ext;
    assign rd_ext = 32'(signed'(r_rdval));

    // Read address for the value memory at START.
    logic [IW-1:0] rv_idx;
    assign rv_idx = i_item.operation == OP_GET_FIRST ? r_head :
                    i_item.operation == OP_GET_LAST  ? r_tail : r_cur;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmd == DC_START) begin
            r_item  <= i_item;
            r_free  <= free_idx;
            r_a     <= okx(rd1_idx) ? (rd1_prev ? mem_prev[rd1_idx[AW-1:0]]
                                                : mem_next[rd1_idx[AW-1:0]]) : NONE;
            r_rdval <= okx(rv_idx) ? mem_val[rv_idx[AW-1:0]] : '0;
        end
        if (i_ctl.cmd == DC_READ2) begin
            r_b <= okx(r_a) ? ((op == OP_DEL_BEFORE) ? mem_prev[r_a[AW-1:0]]
                                                     : mem_next[r_a[AW-1:0]]) : NONE;
        end
        if (i_ctl.cmd == DC_EXEC) begin
            case (op)
                OP_INS_FIRST: if (okx(r_free)) begin
                    mem_val[r_free[AW-1:0]]  <= val_in;
                    mem_next[r_free[AW-1:0]] <= r_head;
                    mem_prev[r_free[AW-1:0]] <= NONE;
                    if (okx(r_head)) mem_prev[r_head[AW-1:0]] <= r_free;
                end
                OP_INS_LAST: if (okx(r_free)) begin
                    mem_val[r_free[AW-1:0]]  <= val_in;
                    mem_prev[r_free[AW-1:0]] <= r_tail;
                    mem_next[r_free[AW-1:0]] <= NONE;
                    if (okx(r_tail)) mem_next[r_tail[AW-1:0]] <= r_free;
                end
                OP_DEL_FIRST: if (okx(r_head) && r_head != r_tail && okx(r_a))
                    mem_prev[r_a[AW-1:0]] <= NONE;
                OP_DEL_LAST: if (okx(r_tail) && r_head != r_tail && okx(r_a))
                    mem_next[r_a[AW-1:0]] <= NONE;
                OP_DEL_AFTER: if (okx(r_cur) && r_cur != r_tail && okx(r_a)) begin
                    mem_next[r_cur[AW-1:0]] <= r_b;
                    if (okx(r_b)) mem_prev[r_b[AW-1:0]] <= r_cur;
                end
                OP_DEL_BEFORE: if (okx(r_cur) && r_cur != r_head && okx(r_a)) begin
                    mem_prev[r_cur[AW-1:0]] <= r_b;
                    if (okx(r_b)) mem_next[r_b[AW-1:0]] <= r_cur;
                end
                OP_INS_AFTER: if (okx(r_cur) && okx(r_free)) begin
                    mem_val[r_free[AW-1:0]]  <= val_in;
                    mem_next[r_free[AW-1:0]] <= r_a;
                    mem_prev[r_free[AW-1:0]] <= r_cur;
                    mem_next[r_cur[AW-1:0]]  <= r_free;
                    if (okx(r_a)) mem_prev[r_a[AW-1:0]] <= r_free;
                end
                OP_INS_BEFORE: if (okx(r_cur) && okx(r_free)) begin
                    mem_val[r_free[AW-1:0]]  <= val_in;
                    mem_prev[r_free[AW-1:0]] <= r_a;
                    mem_next[r_free[AW-1:0]] <= r_cur;
                    mem_prev[r_cur[AW-1:0]]  <= r_free;
                    if (okx(r_a)) mem_next[r_a[AW-1:0]] <= r_free;
                end
                OP_SET_ACTIVE: if (okx(r_cur)) mem_val[r_cur[AW-1:0]] <= val_in;
                default: ;
            endcase
        end
    end

    // Control-side registers and result.
    logic [POOL_DEPTH-1:0] n_used;
    logic [IW-1:0]         n_head, n_tail, n_cur;
    logic [CW-1:0]         n_total;
    t_out_item             n_res;
    logic                  fr_en;
    logic [IW-1:0]         fr_idx;

    always_comb begin
        n_used  = r_used;
        n_head  = r_head;
        n_tail  = r_tail;
        n_cur   = r_cur;
        n_total = r_total;
        fr_en   = 1'b0;
        fr_idx  = r_a;
        n_res   = '0;
        case (op)
            OP_CLEAR: begin
                n_used = '0; n_head = NONE; n_tail = NONE; n_cur = NONE; n_total = '0;
            end
            OP_INS_FIRST, OP_INS_LAST: begin
                if (!okx(r_free)) n_res.error_code = ERR_FULL;
                else begin
                    n_used[r_free[AW-1:0]] = 1'b1;
                    n_total = r_total + 1'b1;
                    if (op == OP_INS_FIRST) begin
                        n_head = r_free;
                        if (!okx(r_head)) n_tail = r_free;
                    end else begin
                        n_tail = r_free;
                        if (!okx(r_tail)) n_head = r_free;
                    end
                end
            end
            OP_GO_FIRST: n_cur = r_head;
            OP_GO_LAST:  n_cur = r_tail;
            OP_GET_FIRST: if (!okx(r_head)) n_res.error_code = ERR_EMPTY;
                          else n_res.read_value = rd_ext;
            OP_GET_LAST:  if (!okx(r_tail)) n_res.error_code = ERR_EMPTY;
                          else n_res.read_value = rd_ext;
            OP_GET_ACTIVE: if (!okx(r_cur)) n_res.error_code = ERR_INACTIVE;
                           else n_res.read_value = rd_ext;
            OP_DEL_FIRST: if (okx(r_head)) begin
                if (r_cur == r_head) n_cur = NONE;
                if (r_head == r_tail) begin n_head = NONE; n_tail = NONE; end
                else n_head = r_a;
                fr_en = 1'b1; fr_idx = r_head;
            end
            OP_DEL_LAST: if (okx(r_tail)) begin
                if (r_cur == r_tail) n_cur = NONE;
                if (r_head == r_tail) begin n_head = NONE; n_tail = NONE; end
                else n_tail = r_a;
                fr_en = 1'b1; fr_idx = r_tail;
            end
            OP_DEL_AFTER: if (okx(r_cur) && r_cur != r_tail && okx(r_a)) begin
                if (!okx(r_b)) n_tail = r_cur;
                fr_en = 1'b1;
            end
            OP_DEL_BEFORE: if (okx(r_cur) && r_cur != r_head && okx(r_a)) begin
                if (!okx(r_b)) n_head = r_cur;
                fr_en = 1'b1;
            end
            OP_INS_AFTER, OP_INS_BEFORE: if (okx(r_cur)) begin
                if (!okx(r_free)) n_res.error_code = ERR_FULL;
                else begin
                    n_used[r_free[AW-1:0]] = 1'b1;
                    n_total = r_total + 1'b1;
                    if (!okx(r_a)) begin
                        if (op == OP_INS_AFTER) n_tail = r_free;
                        else n_head = r_free;
                    end
                end
            end
            OP_NEXT, OP_PREVIOUS: if (okx(r_cur)) n_cur = r_a;
            default: ;
        endcase
        if (fr_en && okx(fr_idx) && r_used[fr_idx[AW-1:0]]) begin
            n_used[fr_idx[AW-1:0]] = 1'b0;
            if (n_total != '0) n_total = n_total - 1'b1;
        end
        n_res.cursor_active = okx(n_cur);
        n_res.entry_count   = 7'(n_total);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_head  <= NONE;
            r_tail  <= NONE;
            r_cur   <= NONE;
            r_total <= '0;
        end else if (i_ctl.cmd == DC_EXEC) begin
            r_used  <= n_used;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_cur   <= n_cur;
            r_total <= n_total;
        end
        if (i_ctl.cmd == DC_EXEC) r_res <= n_res;
    end

    assign o_sts.done = (i_ctl.cmd == DC_EXEC);
    assign o_result   = r_res;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CW'(POOL_DEPTH)) else $error("node count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_total == '0) |-> (r_head == NONE && r_tail == NONE && r_cur == NONE))
        else $error("empty list with live pointer");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        okx(r_head) == okx(r_tail)) else $error("head and tail disagree");
endmodule

// ===== hw/rtl/dllc_ctrl.sv =====
// Controller: sequences each item through read, read, commit, and output handshake.
// Depends on dllc_pkg.
module dllc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  dllc_pkg::t_sts i_sts,
    output dllc_pkg::t_ctl o_ctl
);
    import dllc_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_READ2, S_EXEC} t_state;
    t_state r_state;
    logic   r_out_valid;
    logic   res_free;

    // Accept a new item whenever idle; a waiting result holds the commit step instead.
    assign res_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        case (r_state)
            S_IDLE:  o_ctl.cmd = (i_in_valid && o_in_ready) ? DC_START : DC_IDLE;
            S_READ2: o_ctl.cmd = DC_READ2;
            S_EXEC:  o_ctl.cmd = res_free ? DC_EXEC : DC_IDLE;
            default: o_ctl.cmd = DC_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE:  if (i_in_valid && o_in_ready) r_state <= S_READ2;
                S_READ2: r_state <= S_EXEC;
                S_EXEC: begin
                    if (res_free) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= i_sts.done;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> r_out_valid) else $error("result not posted");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_in_ready) else $error("accept while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ2) |-> $past(r_state == S_IDLE)) else $error("bad sequence");
endmodule

// ===== hw/rtl/doubly_linked_list_cursor_engine_unit.sv =====
// Doubly linked list of signed values in a fixed node pool, with a cursor.
// Each item carries one list operation and yields exactly one result item.
// An item passes three steps (latch and first link read, neighbor's link
// read, commit); its result is registered at the commit step, and the block
// takes no new item until the last one has committed; the steps follow the
// chain of dependent node-memory reads. The next item is accepted while the
// previous result still waits on the output; only its commit step holds
// until the output register is free.
// Nodes are taken lowest free index first; clear frees all at its commit.
// Depends on dllc_pkg, dllc_ctrl, dllc_datapath.
module doubly_linked_list_cursor_engine_unit #(
    parameter int POOL_DEPTH = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dllc_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output dllc_pkg::t_out_item o_out_item
);
    import dllc_pkg::*;

    t_ctl ctl;
    t_sts sts;

    // Sequence each item through the datapath.
    dllc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_ctl       (ctl)
    );

    // Hold the node pool and list pointers.
    dllc_datapath #(
        .POOL_DEPTH (POOL_DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_in_item),
        .i_ctl    (ctl),
        .o_sts    (sts),
        .o_result (o_out_item)
    );
endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the linked-list cursor engine: random and directed list
// operations, predicted by a pool model kept here, compared item by item.
// Depends on dllc_pkg and doubly_linked_list_cursor_engine_unit.
module tb_top;
    import dllc_pkg::*;

    localparam int DEPTH = 64;
    localparam logic [6:0] NIL = 7'd64;
    localparam int N_RANDOM = 750;
    localparam int CYCLE_LIMIT = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic i_out_ready = 1'b0;
    t_in_item i_in_item = '0;
    logic o_in_ready, o_out_valid;
    t_out_item o_out_item;

    int errors = 0;
    int cycles = 0;
    bit stim_done = 1'b0;

    // Hold the pool image that the block should carry.
    logic signed [31:0] pool_val [DEPTH];
    logic [6:0] pool_nxt [DEPTH];
    logic [6:0] pool_prv [DEPTH];
    bit pool_busy [DEPTH];
    logic [6:0] head_q, tail_q, cur_q;
    logic [6:0] used_q;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    class list_scoreboard;
        t_out_item pending[$];

        function void clear_pool();
            for (int i = 0; i < DEPTH; i++) pool_busy[i] = 1'b0;
            head_q = NIL; tail_q = NIL; cur_q = NIL; used_q = '0;
        endfunction

        function logic [6:0] grab(logic signed [31:0] v);
            for (int i = 0; i < DEPTH; i++) begin
                if (!pool_busy[i]) begin
                    pool_busy[i] = 1'b1;
                    pool_val[i] = v;
                    pool_nxt[i] = NIL;
                    pool_prv[i] = NIL;
                    used_q++;
                    return 7'(i);
                end
            end
            return NIL;
        endfunction

        function void drop(logic [6:0] i);
            if (i != NIL && pool_busy[i]) begin
                pool_busy[i] = 1'b0;
                used_q--;
            end
        endfunction

        // Apply one operation and queue the result it should give.
        function void note_input(t_in_item it);
            t_out_item r;
            logic [6:0] n, a, b;
            bit act;
            act = (cur_q != NIL);
            r = '0;
            r.error_code = ERR_OK;
            case (it.operation)
                OP_CLEAR: clear_pool();
                OP_INS_FIRST: begin
                    n = grab(it.value);
                    if (n == NIL) r.error_code = ERR_FULL;
                    else begin
                        pool_nxt[n] = head_q;
                        if (head_q != NIL) pool_prv[head_q] = n; else tail_q = n;
                        head_q = n;
                    end
                end
                OP_INS_LAST: begin
                    n = grab(it.value);
                    if (n == NIL) r.error_code = ERR_FULL;
                    else begin
                        pool_prv[n] = tail_q;
                        if (tail_q != NIL) pool_nxt[tail_q] = n; else head_q = n;
                        tail_q = n;
                    end
                end
                OP_GO_FIRST: cur_q = head_q;
                OP_GO_LAST: cur_q = tail_q;
                OP_GET_FIRST: begin
                    if (head_q == NIL) r.error_code = ERR_EMPTY;
                    else r.read_value = pool_val[head_q];
                end
                OP_GET_LAST: begin
                    if (tail_q == NIL) r.error_code = ERR_EMPTY;
                    else r.read_value = pool_val[tail_q];
                end
                OP_DEL_FIRST: begin
                    a = head_q;
                    if (a != NIL) begin
                        if (cur_q == a) cur_q = NIL;
                        if (a == tail_q) begin
                            head_q = NIL; tail_q = NIL;
                        end else begin
                            head_q = pool_nxt[a];
                            pool_prv[head_q] = NIL;
                        end
                        drop(a);
                    end
                end
                OP_DEL_LAST: begin
                    a = tail_q;
                    if (a != NIL) begin
                        if (cur_q == a) cur_q = NIL;
                        if (a == head_q) begin
                            head_q = NIL; tail_q = NIL;
                        end else begin
                            tail_q = pool_prv[a];
                            pool_nxt[tail_q] = NIL;
                        end
                        drop(a);
                    end
                end
                OP_DEL_AFTER: begin
                    if (act && cur_q != tail_q && pool_nxt[cur_q] != NIL) begin
                        a = pool_nxt[cur_q];
                        b = pool_nxt[a];
                        pool_nxt[cur_q] = b;
                        if (b != NIL) pool_prv[b] = cur_q; else tail_q = cur_q;
                        drop(a);
                    end
                end
                OP_DEL_BEFORE: begin
                    if (act && cur_q != head_q && pool_prv[cur_q] != NIL) begin
                        a = pool_prv[cur_q];
                        b = pool_prv[a];
                        pool_prv[cur_q] = b;
                        if (b != NIL) pool_nxt[b] = cur_q; else head_q = cur_q;
                        drop(a);
                    end
                end
                OP_INS_AFTER: begin
                    if (act) begin
                        n = grab(it.value);
                        if (n == NIL) r.error_code = ERR_FULL;
                        else begin
                            b = pool_nxt[cur_q];
                            pool_nxt[n] = b;
                            pool_prv[n] = cur_q;
                            pool_nxt[cur_q] = n;
                            if (b != NIL) pool_prv[b] = n; else tail_q = n;
                        end
                    end
                end
                OP_INS_BEFORE: begin
                    if (act) begin
                        n = grab(it.value);
                        if (n == NIL) r.error_code = ERR_FULL;
                        else begin
                            b = pool_prv[cur_q];
                            pool_prv[n] = b;
                            pool_nxt[n] = cur_q;
                            pool_prv[cur_q] = n;
                            if (b != NIL) pool_nxt[b] = n; else head_q = n;
                        end
                    end
                end
                OP_GET_ACTIVE: begin
                    if (!act) r.error_code = ERR_INACTIVE;
                    else r.read_value = pool_val[cur_q];
                end
                OP_SET_ACTIVE: if (act) pool_val[cur_q] = it.value;
                OP_NEXT: if (act) cur_q = pool_nxt[cur_q];
                OP_PREVIOUS: if (act) cur_q = pool_prv[cur_q];
                default: ;
            endcase
            r.cursor_active = (cur_q != NIL);
            r.entry_count = used_q;
            pending.push_back(r);
        endfunction

        task check_result(t_out_item got);
            t_out_item w;
            if (pending.size() == 0) begin
                report("unexpected item", got.read_value, 0);
                return;
            end
            w = pending.pop_front();
            if (got.read_value !== w.read_value) report("read_value", got.read_value, w.read_value);
            if (got.error_code !== w.error_code) report("error_code", got.error_code, w.error_code);
            if (got.cursor_active !== w.cursor_active)
                report("cursor_active", got.cursor_active, w.cursor_active);
            if (got.entry_count !== w.entry_count)
                report("entry_count", got.entry_count, w.entry_count);
        endtask
    endclass

    list_scoreboard sb = new();

    doubly_linked_list_cursor_engine_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_item(o_out_item)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Sample the result handshake at the rising edge.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_item);
        if (cycles > CYCLE_LIMIT) begin
            $display("[doubly_linked_list_cursor_engine_unit] ERROR");
            $finish;
        end
    end

    // Stall the result side: alternate long free-flow stretches with random back-pressure.
    initial begin
        int mode;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            mode = (cycles / 300) % 3;
            if (mode == 0) i_out_ready <= 1'b1;
            else if (mode == 1) i_out_ready <= ($urandom_range(0, 3) != 0);
            else i_out_ready <= ($urandom_range(0, 2) == 0);
        end
    end

    int burst_left = 0;

    // Offer one item and hold it until accepted; open gaps between bursts.
    task automatic send_item(input logic [4:0] op, input logic signed [31:0] v);
        t_in_item it;
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        it.operation = op;
        it.value = v;
        i_in_item <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(it);
        @(negedge i_clk);
        // Drop valid only where a gap follows; a burst keeps it high.
        if (burst_left == 0) i_in_valid <= 1'b0;
    endtask

    // Drop valid and wait until every expected result has come.
    task automatic drain();
        if (burst_left != 0) i_in_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return $urandom();
        endcase
    endfunction

    // Favor operations that build and walk the list; sometimes push unused codes.
    function automatic logic [4:0] pick_op(int fill_bias);
        int r;
        r = $urandom_range(0, 99);
        if (r < 2) return OP_CLEAR;
        if (r < 4) return 5'($urandom_range(17, 31));
        if (r < 4 + fill_bias) return 5'($urandom_range(OP_INS_FIRST, OP_INS_LAST));
        if (r < 12 + fill_bias) return 5'($urandom_range(OP_INS_AFTER, OP_INS_BEFORE));
        return 5'($urandom_range(OP_GO_FIRST, OP_PREVIOUS));
    endfunction

    initial begin
        sb.clear_pool();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: errors on an empty list, both ends, cursor walks.
        send_item(OP_GET_FIRST, 0);
        send_item(OP_GET_LAST, 0);
        send_item(OP_GET_ACTIVE, 0);
        send_item(OP_INS_AFTER, 5);
        send_item(OP_DEL_FIRST, 0);
        send_item(OP_GO_FIRST, 0);
        send_item(OP_INS_FIRST, 32'sh7fffffff);
        send_item(OP_INS_LAST, 32'sh80000000);
        send_item(OP_GO_FIRST, 0);
        send_item(OP_INS_BEFORE, -1);
        send_item(OP_INS_AFTER, 3);
        send_item(OP_NEXT, 0);
        send_item(OP_SET_ACTIVE, 32'sh55aa55aa);
        send_item(OP_GET_ACTIVE, 0);
        send_item(OP_DEL_BEFORE, 0);
        send_item(OP_DEL_AFTER, 0);
        send_item(OP_GO_LAST, 0);
        send_item(OP_DEL_AFTER, 0);
        send_item(OP_PREVIOUS, 0);
        send_item(OP_GET_LAST, 0);
        send_item(OP_DEL_LAST, 0);
        send_item(OP_NEXT, 0);
        send_item(5'd31, 0);
        send_item(OP_GET_FIRST, 0);
        send_item(OP_CLEAR, 0);

        // Fill the pool past full so inserts overflow.
        for (int i = 0; i < 66; i++) send_item(OP_INS_LAST, $urandom());
        send_item(OP_GO_FIRST, 0);
        send_item(OP_INS_AFTER, 1);
        send_item(OP_INS_BEFORE, 2);
        send_item(OP_INS_FIRST, 3);

        // Let every pending result drain before the random part.
        drain();
        send_item(OP_CLEAR, 0);

        for (int i = 0; i < N_RANDOM; i++) begin
            // Keep a cursor alive most of the time and vary insert pressure.
            if (cur_q == NIL && $urandom_range(0, 2) != 0)
                send_item($urandom_range(0, 1) ? OP_GO_FIRST : OP_GO_LAST, 0);
            else
                send_item(pick_op(((i / 200) % 2) ? 40 : 15), rand_value());
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (errors == 0 && sb.pending.size() == 0)
            $display("[doubly_linked_list_cursor_engine_unit] OK");
        else
            $display("[doubly_linked_list_cursor_engine_unit] ERROR");
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/dllc_pkg.sv
hw/rtl/dllc_datapath.sv
hw/rtl/dllc_ctrl.sv
hw/rtl/doubly_linked_list_cursor_engine_unit.sv
bench/tb_top.sv
